### hw/rtl/rrsp_pkg.sv
`default_nettype none
package rrsp_pkg;

    localparam int LENGTH_BITS   = 30;
    localparam int COUNT_BITS    = 21;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_BULK_LENGTH    = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_ARGUMENT_COUNT = CFG_ADDR_BITS'(1);

    localparam logic [LENGTH_BITS-1:0] MAX_BULK_RESET = LENGTH_BITS'(536870912);
    localparam logic [COUNT_BITS-1:0]  MAX_ARGS_RESET = COUNT_BITS'(1048576);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] TRAILER_LEN = 2'd2;
    localparam logic [31:0] ACC_SAT_LIMIT = 32'd429496729;

    typedef enum logic [2:0] {
        M_IDLE,
        M_INLINE,
        M_COUNT,
        M_DOLLAR,
        M_LENGTH,
        M_DATA,
        M_TRAILER,
        M_SKIP
    } t_mode;

    typedef enum logic [1:0] {
        K_BYTE,
        K_ARGEND,
        K_CMDEND,
        K_ABORT
    } t_kind;

    typedef enum logic [1:0] {
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } t_nphase;

    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        t_nphase     phase;
    } t_num;

    // One queue entry holds every result that a single input byte causes.
    typedef struct packed {
        logic       two;
        t_kind      kind0;
        logic [7:0] byte0;
        t_kind      kind1;
    } t_entry;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/rrsp_front.sv
`default_nettype none
module rrsp_front
    import rrsp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_accept,
    input  wire logic [7:0]               i_byte,
    output logic                          o_push,
    output t_entry                        o_entry
);

    t_mode                  r_mode, n_mode;
    t_num                   r_num, n_num;
    logic [COUNT_BITS-1:0]  r_args, n_args;
    logic [LENGTH_BITS-1:0] r_bulk, n_bulk;
    logic [1:0]             r_trail, n_trail;
    logic [1:0]             r_flags, n_flags;
    logic [LENGTH_BITS-1:0] r_max_bulk;
    logic [COUNT_BITS-1:0]  r_max_args;

    logic [1:0]             cnt;
    t_entry                 ent;
    logic [1:0]             fl;
    logic                   num_neg;
    logic [COUNT_BITS-1:0]  args_dec;
    logic [LENGTH_BITS-1:0] bulk_dec;

    function automatic t_num num_feed(input t_num cur, input logic [7:0] b);
        t_num        nx;
        logic [31:0] times10;
        nx = cur;
        times10 = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0};
        if (cur.phase == NP_SIGN && is_blank(b)) begin
            nx = cur;
        end else if (cur.phase == NP_SIGN && (b == CH_PLUS || b == CH_MINUS)) begin
            nx.neg   = (b == CH_MINUS);
            nx.phase = NP_DIGITS;
        end else if (cur.phase != NP_DONE) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                nx.phase = NP_DIGITS;
                if (cur.acc >= ACC_SAT_LIMIT) begin
                    nx.acc = '1;
                end else begin
                    nx.acc = times10 + 32'(b - CH_ZERO);
                end
            end else begin
                nx.phase = NP_DONE;
            end
        end
        return nx;
    endfunction

    always_comb begin
        n_mode   = r_mode;
        n_num    = r_num;
        n_args   = r_args;
        n_bulk   = r_bulk;
        n_trail  = r_trail;
        n_flags  = r_flags;
        cnt      = 2'd0;
        ent      = '{two: 1'b0, kind0: K_BYTE, byte0: 8'h00, kind1: K_CMDEND};
        fl       = r_flags;
        num_neg  = r_num.neg && (r_num.acc != 32'd0);
        args_dec = r_args - COUNT_BITS'(1);
        bulk_dec = r_bulk - LENGTH_BITS'(1);

        if (r_mode == M_IDLE) begin
            fl = 2'b00;
        end

        unique case (r_mode)
            M_IDLE, M_INLINE: begin
                if (r_mode == M_IDLE && i_byte == CH_STAR) begin
                    n_num  = '{acc: 32'd0, neg: 1'b0, phase: NP_SIGN};
                    n_mode = M_COUNT;
                end else if (i_byte == CH_LF) begin
                    // A word still open ends first, then the line ends the command.
                    if (fl[0]) begin
                        ent.kind0 = K_ARGEND;
                        ent.two   = fl[1];
                        cnt       = fl[1] ? 2'd2 : 2'd1;
                    end else if (fl[1]) begin
                        ent.kind0 = K_CMDEND;
                        cnt       = 2'd1;
                    end
                    n_flags = 2'b00;
                    n_mode  = M_IDLE;
                end else if (is_blank(i_byte)) begin
                    if (fl[0]) begin
                        ent.kind0 = K_ARGEND;
                        cnt       = 2'd1;
                    end
                    n_flags = {fl[1], 1'b0};
                    n_mode  = M_INLINE;
                end else begin
                    ent.kind0 = K_BYTE;
                    ent.byte0 = i_byte;
                    cnt       = 2'd1;
                    n_flags   = 2'b11;
                    n_mode    = M_INLINE;
                end
            end
            M_COUNT: begin
                if (i_byte != CH_LF) begin
                    n_num = num_feed(r_num, i_byte);
                end else if (num_neg || r_num.acc == 32'd0) begin
                    n_mode = M_IDLE;
                end else if (r_num.acc > 32'(r_max_args)) begin
                    ent.kind0 = K_ABORT;
                    cnt       = 2'd1;
                    n_mode    = M_IDLE;
                end else begin
                    n_args = r_num.acc[COUNT_BITS-1:0];
                    n_mode = M_DOLLAR;
                end
            end
            M_DOLLAR: begin
                if (i_byte == CH_DOLLAR) begin
                    n_num  = '{acc: 32'd0, neg: 1'b0, phase: NP_SIGN};
                    n_mode = M_LENGTH;
                end else begin
                    ent.kind0 = K_ABORT;
                    cnt       = 2'd1;
                    n_mode    = (i_byte == CH_LF) ? M_IDLE : M_SKIP;
                end
            end
            M_LENGTH: begin
                if (i_byte != CH_LF) begin
                    n_num = num_feed(r_num, i_byte);
                end else if (num_neg || r_num.acc > 32'(r_max_bulk)) begin
                    ent.kind0 = K_ABORT;
                    cnt       = 2'd1;
                    n_mode    = M_IDLE;
                end else if (r_num.acc == 32'd0) begin
                    n_trail = TRAILER_LEN;
                    n_mode  = M_TRAILER;
                end else begin
                    n_bulk = r_num.acc[LENGTH_BITS-1:0];
                    n_mode = M_DATA;
                end
            end
            M_DATA: begin
                ent.kind0 = K_BYTE;
                ent.byte0 = i_byte;
                cnt       = 2'd1;
                n_bulk    = bulk_dec;
                if (bulk_dec == '0) begin
                    n_trail = TRAILER_LEN;
                    n_mode  = M_TRAILER;
                end
            end
            M_TRAILER: begin
                if (r_trail > 2'd1) begin
                    n_trail = r_trail - 2'd1;
                end else begin
                    n_trail   = 2'd0;
                    ent.kind0 = K_ARGEND;
                    n_args    = args_dec;
                    if (args_dec == '0) begin
                        ent.two = 1'b1;
                        cnt     = 2'd2;
                        n_mode  = M_IDLE;
                    end else begin
                        cnt    = 2'd1;
                        n_mode = M_DOLLAR;
                    end
                end
            end
            M_SKIP: begin
                if (i_byte == CH_LF) begin
                    n_mode = M_IDLE;
                end
            end
        endcase
    end

    assign o_push  = i_accept && (cnt != 2'd0);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_num   <= '{acc: 32'd0, neg: 1'b0, phase: NP_SIGN};
            r_args  <= '0;
            r_bulk  <= '0;
            r_trail <= 2'd0;
            r_flags <= 2'b00;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_num   <= n_num;
            r_args  <= n_args;
            r_bulk  <= n_bulk;
            r_trail <= n_trail;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bulk <= MAX_BULK_RESET;
            r_max_args <= MAX_ARGS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_MAX_BULK_LENGTH) begin
                r_max_bulk <= i_cfg_data[LENGTH_BITS-1:0];
            end
            if (i_cfg_addr == CFG_MAX_ARGUMENT_COUNT) begin
                r_max_args <= i_cfg_data[COUNT_BITS-1:0];
            end
        end
    end

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_DATA |-> r_bulk != '0)
        else $error("bulk data state with no bytes left");
    a_trailer_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_TRAILER |-> (r_trail == 2'd1 || r_trail == 2'd2))
        else $error("trailer state with bad trailer count");
    a_dollar_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_DOLLAR |-> r_args != '0)
        else $error("expecting an element with none left");

endmodule
`default_nettype wire

### hw/rtl/rrsp_queue.sv
`default_nettype none
module rrsp_queue
    import rrsp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_head
);

    t_entry                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_PTR_BITS+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_PTR_BITS+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

### hw/rtl/rrsp_back.sv
`default_nettype none
module rrsp_back
    import rrsp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_tvalid,
    input  wire logic   i_tready,
    output logic [7:0]  o_tdata,
    output logic [1:0]  o_tuser,
    output logic        o_tlast
);

    logic       r_valid;
    logic       r_sub;
    t_kind      r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;

    // The output register takes a new beat when it is empty or being drained.
    assign load  = i_valid && (!r_valid || i_tready);
    assign o_pop = load && (r_sub || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= !r_sub && i_head.two;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sub) begin
                r_kind <= i_head.kind1;
                r_byte <= 8'h00;
                r_last <= 1'b1;
            end else begin
                r_kind <= i_head.kind0;
                r_byte <= i_head.byte0;
                r_last <= !i_head.two;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_byte;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    a_sub_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> i_valid && i_head.two)
        else $error("second result pending without a two-result entry");
    a_sub_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> r_valid && !r_last)
        else $error("second result pending while first is not shown");
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != K_BYTE |-> r_byte == 8'h00)
        else $error("mark beat carries a data byte");

endmodule
`default_nettype wire

### hw/rtl/resp_request_stream_parser_unit.sv
// Request stream parser for RESP2 arrays and inline command lines.
// Slave channel: one raw client byte per beat on i_s_tdata.
// Master channel: one result per beat. o_m_tuser carries the kind (argument
// byte, argument end, command end, command aborted), o_m_tdata the argument
// byte (zero for marks) and o_m_tlast flags the final result of an input byte.
// Configuration: i_cfg_we with i_cfg_addr 0 writes max_bulk_length and
// 1 writes max_argument_count; write only while the parser is idle.
// Each result passes through a queue entry and then the output register before
// it reaches the master side. Throughput: one input byte per cycle while the
// queue is not full; the parse state machine handles each byte in the cycle
// that accepts it. A byte that causes two results is shown as two beats,
// and a four-entry queue between parser and output stage absorbs these bursts.
// When the receiver stalls the queue fills and o_s_tready drops only when it
// is full. Reset (synchronous, active low) returns the parser to the start of
// a command, empties the queue and restores both limits to their defaults.
`default_nettype none
module resp_request_stream_parser_unit
    import rrsp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [7:0]               i_s_tdata,   // [7:0] in_byte
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    output logic [7:0]                    o_m_tdata,   // [7:0] out_byte
    output logic [1:0]                    o_m_tuser,   // [1:0] out_kind
    output logic                          o_m_tlast
);

    logic   q_full;
    logic   q_valid;
    logic   q_push;
    logic   q_pop;
    t_entry q_in;
    t_entry q_head;
    logic   accept;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    rrsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_byte     (i_s_tdata),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    rrsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    rrsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

### verif/rrsp_stream_checker.sv
`timescale 1ns / 100ps
module rrsp_stream_checker
    import rrsp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [7:0]               i_s_tdata,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [7:0]               i_m_tdata,
    input  logic [1:0]               i_m_tuser,
    input  logic                     i_m_tlast,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_bytes_in,
    output int                       o_tokens_seen,
    output int                       o_commands_done,
    output int                       o_commands_aborted
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_parsed_token;

    t_parsed_token predicted_tokens[$];
    t_parsed_token step_tokens[$];

    // Shadow copy of the parser state and limits.
    t_mode                  mode;
    logic [31:0]            num_acc;
    logic                   num_neg;
    t_nphase                num_phase;
    logic [COUNT_BITS-1:0]  args_left;
    logic [LENGTH_BITS-1:0] bulk_left;
    logic [1:0]             trail_left;
    logic [1:0]             word_flags;
    logic [LENGTH_BITS-1:0] lim_bulk;
    logic [COUNT_BITS-1:0]  lim_args;

    int fail_count = 0;
    int bytes_in = 0;
    int tokens_seen = 0;
    int commands_done = 0;
    int commands_aborted = 0;

    function automatic logic whitespace_byte(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D && b != 8'h0A);
    endfunction

    task automatic reset_shadow();
        mode       = M_IDLE;
        num_acc    = '0;
        num_neg    = 1'b0;
        num_phase  = NP_SIGN;
        args_left  = '0;
        bulk_left  = '0;
        trail_left = '0;
        word_flags = '0;
        lim_bulk   = MAX_BULK_RESET;
        lim_args   = MAX_ARGS_RESET;
    endtask

    task automatic clear_number();
        num_acc   = '0;
        num_neg   = 1'b0;
        num_phase = NP_SIGN;
    endtask

    // A single byte never yields more than two results; extras are dropped.
    task automatic stage_token(input t_kind kind, input logic [7:0] data);
        t_parsed_token tok;
        if (step_tokens.size() < 2) begin
            tok.kind = kind;
            tok.data = (kind == K_BYTE) ? data : 8'h00;
            tok.last = 1'b0;
            step_tokens.insert(step_tokens.size(), tok);
        end
    endtask

    // Decimal field in the manner of atoi, saturating at all ones.
    task automatic feed_decimal(input logic [7:0] b);
        logic consumed;
        consumed = 1'b0;
        if (num_phase == NP_SIGN) begin
            if (whitespace_byte(b)) begin
                consumed = 1'b1;
            end else if (b == CH_PLUS || b == CH_MINUS) begin
                num_neg   = (b == CH_MINUS);
                num_phase = NP_DIGITS;
                consumed  = 1'b1;
            end else begin
                num_phase = NP_DIGITS;
            end
        end
        if (!consumed && num_phase == NP_DIGITS) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                if (num_acc >= ACC_SAT_LIMIT)
                    num_acc = '1;
                else
                    num_acc = num_acc * 32'd10 + 32'(b - CH_ZERO);
            end else begin
                num_phase = NP_DONE;
            end
        end
    endtask

    function automatic logic number_below_zero();
        return num_neg && num_acc != 32'd0;
    endfunction

    task automatic inline_char(input logic [7:0] b);
        if (b == CH_LF) begin
            if (word_flags[0]) stage_token(K_ARGEND, 8'h00);
            if (word_flags[1]) stage_token(K_CMDEND, 8'h00);
            word_flags = 2'b00;
            mode       = M_IDLE;
        end else if (whitespace_byte(b)) begin
            if (word_flags[0]) stage_token(K_ARGEND, 8'h00);
            word_flags[0] = 1'b0;
        end else begin
            stage_token(K_BYTE, b);
            word_flags = 2'b11;
        end
    endtask

    task automatic parse_request_byte(input logic [7:0] b);
        step_tokens.delete();
        case (mode)
            M_IDLE: begin
                if (b == CH_STAR) begin
                    clear_number();
                    mode = M_COUNT;
                end else begin
                    word_flags = 2'b00;
                    mode       = M_INLINE;
                    inline_char(b);
                end
            end
            M_INLINE: inline_char(b);
            M_COUNT: begin
                if (b != CH_LF) begin
                    feed_decimal(b);
                end else if (number_below_zero() || num_acc == 32'd0) begin
                    mode = M_IDLE;
                end else if (num_acc > 32'(lim_args)) begin
                    stage_token(K_ABORT, 8'h00);
                    mode = M_IDLE;
                end else begin
                    args_left = num_acc[COUNT_BITS-1:0];
                    mode      = M_DOLLAR;
                end
            end
            M_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    clear_number();
                    mode = M_LENGTH;
                end else begin
                    stage_token(K_ABORT, 8'h00);
                    mode = (b == CH_LF) ? M_IDLE : M_SKIP;
                end
            end
            M_LENGTH: begin
                if (b != CH_LF) begin
                    feed_decimal(b);
                end else if (number_below_zero() || num_acc > 32'(lim_bulk)) begin
                    stage_token(K_ABORT, 8'h00);
                    mode = M_IDLE;
                end else if (num_acc == 32'd0) begin
                    trail_left = TRAILER_LEN;
                    mode       = M_TRAILER;
                end else begin
                    bulk_left = num_acc[LENGTH_BITS-1:0];
                    mode      = M_DATA;
                end
            end
            M_DATA: begin
                stage_token(K_BYTE, b);
                bulk_left = bulk_left - 1'b1;
                if (bulk_left == '0) begin
                    trail_left = TRAILER_LEN;
                    mode       = M_TRAILER;
                end
            end
            M_TRAILER: begin
                if (trail_left > 2'd1) begin
                    trail_left = trail_left - 2'd1;
                end else begin
                    trail_left = 2'd0;
                    stage_token(K_ARGEND, 8'h00);
                    args_left = args_left - 1'b1;
                    if (args_left == '0) begin
                        stage_token(K_CMDEND, 8'h00);
                        mode = M_IDLE;
                    end else begin
                        mode = M_DOLLAR;
                    end
                end
            end
            default: begin
                if (b == CH_LF) mode = M_IDLE;
            end
        endcase
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[k]) predicted_tokens.insert(predicted_tokens.size(), step_tokens[k]);
    endtask

    task automatic check_token();
        t_parsed_token want;
        tokens_seen++;
        if (predicted_tokens.size() == 0) begin
            fail_count++;
            $display("%0t: result with none expected: kind %0d byte %02h last %0b",
                     $time, i_m_tuser, i_m_tdata, i_m_tlast);
        end else begin
            want = predicted_tokens.pop_front();
            if (t_kind'(i_m_tuser) != want.kind) begin
                fail_count++;
                $display("%0t: kind expected %0d, got %0d", $time, want.kind, i_m_tuser);
            end
            if (i_m_tdata != want.data) begin
                fail_count++;
                $display("%0t: byte expected %02h, got %02h", $time, want.data, i_m_tdata);
            end
            if (i_m_tlast != want.last) begin
                fail_count++;
                $display("%0t: last expected %0b, got %0b", $time, want.last, i_m_tlast);
            end
            if (want.kind == K_CMDEND) commands_done++;
            if (want.kind == K_ABORT) commands_aborted++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
            predicted_tokens.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_MAX_BULK_LENGTH)
                    lim_bulk = i_cfg_data[LENGTH_BITS-1:0];
                else if (i_cfg_addr == CFG_MAX_ARGUMENT_COUNT)
                    lim_args = i_cfg_data[COUNT_BITS-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                bytes_in++;
                parse_request_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) check_token();
        end
        o_pending          <= predicted_tokens.size();
        o_fail_count       <= fail_count;
        o_bytes_in         <= bytes_in;
        o_tokens_seen      <= tokens_seen;
        o_commands_done    <= commands_done;
        o_commands_aborted <= commands_aborted;
    end

endmodule

### verif/tb_resp_request_stream_parser_unit.sv
`timescale 1ns / 100ps
module tb_resp_request_stream_parser_unit;
    import rrsp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [7:0]               i_s_tdata = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [7:0]               o_m_tdata;
    logic [1:0]               o_m_tuser;
    logic                     o_m_tlast;

    int fail_count;
    int pending;
    int bytes_in;
    int tokens_seen;
    int commands_done;
    int commands_aborted;

    logic [7:0]      request_bytes[$];
    int              burst_left = 0;
    longint unsigned cur_bulk;
    longint unsigned cur_args;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    resp_request_stream_parser_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    rrsp_stream_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_s_tvalid         (i_s_tvalid),
        .i_s_tready         (o_s_tready),
        .i_s_tdata          (i_s_tdata),
        .i_m_tvalid         (o_m_tvalid),
        .i_m_tready         (i_m_tready),
        .i_m_tdata          (o_m_tdata),
        .i_m_tuser          (o_m_tuser),
        .i_m_tlast          (o_m_tlast),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_bytes_in         (bytes_in),
        .o_tokens_seen      (tokens_seen),
        .o_commands_done    (commands_done),
        .o_commands_aborted (commands_aborted)
    );

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            3: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        request_bytes.insert(request_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    task automatic add_line_end();
        if ($urandom_range(0, 1)) add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    // Leading blanks, signs, leading zeros and trailing junk all exercise
    // the atoi-style field parsing.
    task automatic add_decimal(input longint unsigned value, input bit minus);
        int pad;
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) add_byte(pick_blank());
        if (minus)
            add_byte(CH_MINUS);
        else if ($urandom_range(0, 4) == 0)
            add_byte(CH_PLUS);
        if ($urandom_range(0, 5) == 0) add_byte(CH_ZERO);
        add_text($sformatf("%0d", value));
        if ($urandom_range(0, 5) == 0) add_text(" x");
    endtask

    task automatic add_element(input longint unsigned len);
        add_byte(CH_DOLLAR);
        add_decimal(len, 1'b0);
        add_line_end();
        repeat (len) add_byte(8'($urandom_range(0, 255)));
        repeat (2) add_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic longint unsigned pick_length();
        longint unsigned ceiling;
        ceiling = (cur_bulk < 6) ? cur_bulk : 6;
        if (cur_bulk <= 9 && $urandom_range(0, 3) == 0) return cur_bulk;
        return $urandom_range(0, int'(ceiling));
    endfunction

    function automatic longint unsigned pick_count();
        longint unsigned ceiling;
        ceiling = (cur_args < 3) ? cur_args : 3;
        if (cur_args <= 4 && $urandom_range(0, 3) == 0) return cur_args;
        return $urandom_range(1, int'(ceiling));
    endfunction

    task automatic add_inline_line();
        int         words;
        logic [7:0] b;
        bit         at_start;
        words    = $urandom_range(0, 3);
        at_start = 1'b1;
        if ($urandom_range(0, 2) == 0) begin
            add_byte(pick_blank());
            at_start = 1'b0;
        end
        for (int w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom_range(0, 255));
                // Flipping bit 6 turns a separator or a star into a word byte.
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || (at_start && b == CH_STAR))
                    b = b ^ 8'h40;
                add_byte(b);
                at_start = 1'b0;
            end
            if (w < words - 1 || $urandom_range(0, 1))
                repeat ($urandom_range(1, 2)) add_byte(pick_blank());
        end
        add_line_end();
    endtask

    task automatic add_random_command();
        int              pick;
        longint unsigned count;
        logic [7:0]      b;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            count = pick_count();
            add_byte(CH_STAR);
            add_decimal(count, 1'b0);
            add_line_end();
            repeat (count) add_element(pick_length());
        end else if (pick < 70) begin
            add_inline_line();
        end else if (pick < 75) begin
            // Counts up to five, some negative; zero or negative counts drop the line.
            add_byte(CH_STAR);
            add_decimal($urandom_range(0, 5), 1'($urandom_range(0, 1)));
            add_line_end();
        end else if (pick < 80) begin
            add_byte(CH_STAR);
            if ($urandom_range(0, 2) != 0)
                add_decimal(cur_args + 1 + $urandom_range(0, 3), 1'b0);
            else
                add_text("98765432109");
            add_line_end();
        end else if (pick < 86) begin
            // Missing dollar, sometimes after an element was already emitted.
            count = (cur_args >= 2 && $urandom_range(0, 1)) ? 2 : 1;
            add_byte(CH_STAR);
            add_decimal(count, 1'b0);
            add_line_end();
            if (count == 2) add_element(pick_length());
            if ($urandom_range(0, 2) == 0) begin
                add_byte(CH_LF);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_DOLLAR || b == CH_LF) b = 8'h23;
                add_byte(b);
                repeat ($urandom_range(0, 4)) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_LF) b = CH_CR;
                    add_byte(b);
                end
                add_byte(CH_LF);
            end
        end else if (pick < 92) begin
            add_byte(CH_STAR);
            add_decimal(1, 1'b0);
            add_line_end();
            add_byte(CH_DOLLAR);
            case ($urandom_range(0, 2))
                0: add_decimal($urandom_range(1, 9), 1'b1);
                1: add_decimal(cur_bulk + 1 + $urandom_range(0, 3), 1'b0);
                default: add_text("4294967296");
            endcase
            add_line_end();
        end else begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            add_byte(CH_LF);
        end
    endtask

    task automatic set_limits(input longint unsigned bulk, input longint unsigned args);
        cur_bulk = bulk;
        cur_args = args;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_MAX_BULK_LENGTH;
        i_cfg_data <= CFG_DATA_BITS'(bulk);
        @(posedge i_clk);
        i_cfg_addr <= CFG_MAX_ARGUMENT_COUNT;
        i_cfg_data <= CFG_DATA_BITS'(args);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_stream();
        while (request_bytes.size() > 0) begin
            if (burst_left == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 16);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= request_bytes.pop_front();
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            burst_left--;
        end
        i_s_tvalid <= 1'b0;
    endtask

    // Bytes such as the first trailer byte produce nothing, so the wait runs on
    // past the last expected result to cover the pipeline.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_random(input int target);
        while (request_bytes.size() < target) add_random_command();
        send_stream();
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_limits(MAX_BULK_RESET, MAX_ARGS_RESET);

        // Data bytes at both extremes, then a two-word inline line with tab.
        add_text("*1\n$2\n");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("\r\n");
        add_text("a\tb \n");
        // Empty line, zero-length bulk string, and a missing dollar.
        add_text("\n");
        add_text("*1\n$0\n\r\n");
        add_text("*1\nx\n");
        run_random(170);

        set_limits(3, 2);
        run_random(130);
        set_limits(0, 1);
        run_random(90);
        set_limits(9, 4);
        run_random(100);

        $display("Run covered %0d request bytes and %0d parser results under four limit pairs.",
                 bytes_in, tokens_seen);
        $display("Commands completed: %0d, commands aborted: %0d.",
                 commands_done, commands_aborted);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver stalls on its own pattern; every twelfth segment is a long
    // hold-off so the output queue fills and back-pressures the input.
    initial begin : receiver
        int seg_count;
        int style;
        seg_count = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            seg_count++;
            if (seg_count % 12 == 3) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                repeat ($urandom_range(8, 50)) begin
                    case (style)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        2: i_m_tready <= ($urandom_range(0, 3) == 0);
                        default: i_m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rrsp_pkg.sv
hw/rtl/rrsp_front.sv
hw/rtl/rrsp_queue.sv
hw/rtl/rrsp_back.sv
hw/rtl/resp_request_stream_parser_unit.sv
verif/rrsp_stream_checker.sv
verif/tb_resp_request_stream_parser_unit.sv
